[rtl/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared widths, constants and controller/datapath interface types for the
// trial-division prime test.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    // Candidate width at the port and inside the datapath
    localparam int IN_W    = 32;
    localparam int VALUE_W = 32;

    // Divisor register holds one past sqrt(2^VALUE_W - 1)
    localparam int DIV_W   = VALUE_W / 2 + 1;
    // Running square of the divisor, one bit wider than the candidate
    localparam int SQ_W    = VALUE_W + 1;
    // Partial remainder of the long division, holds up to 2*divisor
    localparam int REM_W   = DIV_W + 1;
    // Bit counter for one long division
    localparam int CNT_W   = $clog2(VALUE_W);
    // Reported divisor width
    localparam int OUT_W   = 16;

    localparam int FIRST_DIVISOR = 2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // latch a new candidate, reset divisor to 2
        logic set_result;  // capture a verdict into the result stage
        logic res_prime;   // verdict: prime
        logic res_found;   // verdict: current divisor divides the candidate
        logic start_div;   // begin long division by the current divisor
        logic div_step;    // one restoring-division bit
        logic next_div;    // advance to the next divisor
        logic out_load;    // move the result stage to the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic below_two;   // candidate below 2
        logic sq_gt;       // divisor squared exceeds candidate
        logic div_last;    // last bit of the long division
        logic rem_zero;    // remainder is zero
    } status_t;

endpackage

`default_nettype wire

[rtl/tdpt_datapath.sv]
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate and divisor registers, running divisor square, bit-serial
// restoring remainder unit and the result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [tdpt_pkg::IN_W-1:0]   candidate_value,
    input  wire tdpt_pkg::cmd_t              cmd,
    output tdpt_pkg::status_t                status,
    output logic                             is_prime,
    output logic [tdpt_pkg::OUT_W-1:0]       smallest_divisor
);

    logic [tdpt_pkg::VALUE_W-1:0] cand_reg,  cand_next;
    logic [tdpt_pkg::DIV_W-1:0]   div_reg,   div_next;
    logic [tdpt_pkg::SQ_W-1:0]    sq_reg,    sq_next;
    logic [tdpt_pkg::REM_W-1:0]   rem_reg,   rem_next;
    logic [tdpt_pkg::VALUE_W-1:0] shift_reg, shift_next;
    logic [tdpt_pkg::CNT_W-1:0]   cnt_reg,   cnt_next;
    logic                         res_prime_reg, res_prime_next;
    logic [tdpt_pkg::OUT_W-1:0]   res_div_reg,   res_div_next;
    logic                         out_prime_reg, out_prime_next;
    logic [tdpt_pkg::OUT_W-1:0]   out_div_reg,   out_div_next;

    logic [tdpt_pkg::REM_W-1:0]   trial;
    logic [tdpt_pkg::REM_W-1:0]   div_ext;

    // One restoring step: bring down the next candidate bit, subtract if it fits
    assign trial   = {rem_reg[tdpt_pkg::REM_W-2:0], shift_reg[tdpt_pkg::VALUE_W-1]};
    assign div_ext = {1'b0, div_reg};

    // Next-state logic for the datapath registers
    always_comb
    begin
        cand_next      = cand_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        res_prime_next = res_prime_reg;
        res_div_next   = res_div_reg;
        out_prime_next = out_prime_reg;
        out_div_next   = out_div_reg;

        if (cmd.load)
        begin
            cand_next = tdpt_pkg::VALUE_W'(candidate_value);
            div_next  = tdpt_pkg::DIV_W'(tdpt_pkg::FIRST_DIVISOR);
            sq_next   = tdpt_pkg::SQ_W'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
        end

        if (cmd.start_div)
        begin
            rem_next   = '0;
            shift_next = cand_reg;
            cnt_next   = '0;
        end

        if (cmd.div_step)
        begin
            rem_next   = (trial >= div_ext) ? (trial - div_ext) : trial;
            shift_next = {shift_reg[tdpt_pkg::VALUE_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end

        // (d+1)^2 = d^2 + 2d + 1
        if (cmd.next_div)
        begin
            div_next = div_reg + 1'b1;
            sq_next  = sq_reg + tdpt_pkg::SQ_W'({div_reg, 1'b1});
        end

        if (cmd.set_result)
        begin
            res_prime_next = cmd.res_prime;
            res_div_next   = cmd.res_found ? tdpt_pkg::OUT_W'(div_reg) : '0;
        end

        if (cmd.out_load)
        begin
            out_prime_next = res_prime_reg;
            out_div_next   = res_div_reg;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        div_reg       <= div_next;
        sq_reg        <= sq_next;
        rem_reg       <= rem_next;
        shift_reg     <= shift_next;
        res_prime_reg <= res_prime_next;
        res_div_reg   <= res_div_next;
        out_prime_reg <= out_prime_next;
        out_div_reg   <= out_div_next;
    end

    // Bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.below_two = (cand_reg[tdpt_pkg::VALUE_W-1:1] == '0);
        status.sq_gt     = (sq_reg > {1'b0, cand_reg});
        status.div_last  = (cnt_reg == tdpt_pkg::CNT_W'(tdpt_pkg::VALUE_W - 1));
        status.rem_zero  = (rem_reg == '0);
    end

    assign is_prime         = out_prime_reg;
    assign smallest_divisor = out_div_reg;

endmodule

`default_nettype wire

[rtl/tdpt_ctrl.sv]
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for the trial-division search: bound check, long division,
// remainder test, and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire tdpt_pkg::status_t   status,
    output tdpt_pkg::cmd_t           cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_TEST   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // State transitions and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.below_two)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (status.sq_gt)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_prime  = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.rem_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_found  = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: cleared on transfer, set when a result is loaded
    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Decides whether a 32-bit candidate is prime by trial division and reports
// the smallest divisor found.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, candidate_value): one candidate per
//   transfer. in_ready is high only while no candidate is being searched.
//   Output channel (out_valid/out_ready, is_prime, smallest_divisor): one
//   result per candidate, held in an output register until transferred.
//   smallest_divisor is 0 for primes and for candidates 0 and 1.
// Search:
//   Divisors d = 2, 3, ... are tried while d*d <= candidate. Each divisor
//   takes one bound check, a bit-serial remainder and one remainder test.
//   Candidates below 4 finish at the first bound check; in general the
//   search time grows with the number of divisors tried and is longest
//   for a large 32-bit prime.
//   A new candidate is taken the cycle after the result moves to the output
//   register, so the block does not take a new candidate before it has
//   finished with the last one.
// Reset: rst_n clears the sequencer and the output valid; the block comes up
//   idle and ready. If the receiver stalls, the finished result waits in the
//   output register and the next candidate is still taken and searched; its
//   result is held back until the first one is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tdpt_pkg::IN_W-1:0]   candidate_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             is_prime,
    output logic [tdpt_pkg::OUT_W-1:0]       smallest_divisor
);

    tdpt_pkg::cmd_t    cmd;
    tdpt_pkg::status_t status;

    tdpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tdpt_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .candidate_value  (candidate_value),
        .cmd              (cmd),
        .status           (status),
        .is_prime         (is_prime),
        .smallest_divisor (smallest_divisor)
    );

endmodule

`default_nettype wire

[rtl/tdpt_checker.sv]
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks for the trial-division prime test, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic [tdpt_pkg::IN_W-1:0]   candidate_value,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        is_prime,
    input wire logic [tdpt_pkg::OUT_W-1:0]  smallest_divisor
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_prime)
                                   && $stable(smallest_divisor))
        else $error("result changed while stalled");

    // A prime reports no divisor
    a_prime_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_prime |-> smallest_divisor == '0)
        else $error("prime with nonzero divisor");

    // A reported divisor is at least 2
    a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && smallest_divisor != '0 |-> smallest_divisor != 16'd1)
        else $error("divisor of one reported");

    // Busy after taking a candidate
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a transfer");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

`default_nettype wire
